// ===== src/bsfe_pkg.sv =====
// Shared types, codes and constants of the byte stuffing frame encoder.
`default_nettype none

package bsfe_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [BYTE_WIDTH-1:0] CTRL_SEQ0 = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] CTRL_SEQ1 = 8'h40;

   localparam logic [BYTE_WIDTH-1:0] FLAG_VALUE_RESET    = 8'd126;
   localparam logic [BYTE_WIDTH-1:0] ESCAPE_VALUE_RESET  = 8'd125;
   localparam logic [BYTE_WIDTH-1:0] FLAG_CODE_RESET     = 8'd94;
   localparam logic [BYTE_WIDTH-1:0] ESCAPE_CODE_RESET   = 8'd93;
   localparam logic [BYTE_WIDTH-1:0] ADDRESS_VALUE_RESET = 8'd3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FLAG_VALUE    = 3'd0,
      CSR_ESCAPE_VALUE  = 3'd1,
      CSR_FLAG_CODE     = 3'd2,
      CSR_ESCAPE_CODE   = 3'd3,
      CSR_ADDRESS_VALUE = 3'd4
   } csr_index_type;

   // how a byte goes out on the line
   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_FLAG,
      KIND_ESC
   } kind_type;

   typedef enum logic [3:0] {
      ST_BEGIN,
      ST_HDR_FLAG,
      ST_HDR_ADDR,
      ST_HDR_CTRL,
      ST_HDR_PAR,
      ST_DATA0,
      ST_DATA1,
      ST_PAR0,
      ST_PAR1,
      ST_CLOSE
   } step_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] flag_value;
      logic [BYTE_WIDTH-1:0] escape_value;
      logic [BYTE_WIDTH-1:0] flag_code;
      logic [BYTE_WIDTH-1:0] escape_code;
      logic [BYTE_WIDTH-1:0] address_value;
   } cfg_type;

   // one classified request, as queued between front and back
   typedef struct packed {
      logic                  start;
      logic                  seq;
      logic [BYTE_WIDTH-1:0] data;
      kind_type              data_kind;
      logic                  last;
      logic [BYTE_WIDTH-1:0] parity;
      kind_type              par_kind;
   } job_type;

   function automatic kind_type classify(input logic [BYTE_WIDTH-1:0] b,
                                         input cfg_type cfg);
      kind_type k;
      k = KIND_PLAIN;
      if (b == cfg.flag_value) begin
         k = KIND_FLAG;
      end else if (b == cfg.escape_value) begin
         k = KIND_ESC;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== src/bsfe_front.sv =====
// Front end: takes requests, tracks the running parity and classifies bytes.
`default_nettype none

module bsfe_front (
   input  wire                         clock,
   input  wire                         reset,
   input  bsfe_pkg::cfg_type           cfg,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [bsfe_pkg::BYTE_WIDTH-1:0] req_payload_byte,
   input  wire                         req_frame_start,
   input  wire                         req_frame_last,
   input  wire                         req_sequence_bit,
   input  wire                         queue_full,
   output logic                        push,
   output bsfe_pkg::job_type           push_job
);
   import bsfe_pkg::*;

   logic [BYTE_WIDTH-1:0] parity_ff;
   logic [BYTE_WIDTH-1:0] parity_in;
   logic [BYTE_WIDTH-1:0] parity_new;

   assign req_stall  = queue_full;
   assign push       = req_valid && !req_stall;
   assign parity_new = (req_frame_start ? '0 : parity_ff) ^ req_payload_byte;

   always_comb begin
      parity_in = parity_ff;
      if (push) begin
         parity_in = req_frame_last ? '0 : parity_new;
      end
   end

   always_comb begin
      push_job.start     = req_frame_start;
      push_job.seq       = req_sequence_bit;
      push_job.data      = req_payload_byte;
      push_job.data_kind = classify(req_payload_byte, cfg);
      push_job.last      = req_frame_last;
      push_job.parity    = parity_new;
      push_job.par_kind  = classify(parity_new, cfg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= '0;
      end else begin
         parity_ff <= parity_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bsfe_queue.sv =====
// Small queue of classified requests between front and back.
`default_nettype none

module bsfe_queue #(
   parameter int DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  bsfe_pkg::job_type  push_job,
   input  wire                pop,
   output bsfe_pkg::job_type  head_job,
   output logic               full,
   output logic               empty
);
   import bsfe_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   job_type               entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== src/bsfe_back.sv =====
// Back end: walks each queued request out one line byte per cycle while rsp_stall is low.
`default_nettype none

module bsfe_back (
   input  wire                              clock,
   input  wire                              reset,
   input  bsfe_pkg::cfg_type                cfg,
   input  bsfe_pkg::job_type                job,
   input  wire                              job_ready,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [bsfe_pkg::BYTE_WIDTH-1:0]  rsp_line_byte,
   output logic                             rsp_run_end,
   output logic                             rsp_frame_done
);
   import bsfe_pkg::*;

   step_type              step_ff, step_in;
   step_type              cur;
   step_type              following;
   logic                  out_free;
   logic                  emit;
   logic [BYTE_WIDTH-1:0] ctrl_byte;
   logic [BYTE_WIDTH-1:0] byte_out;

   logic                  valid_ff, valid_in;
   logic [BYTE_WIDTH-1:0] byte_ff;
   logic                  run_end_ff;
   logic                  done_ff;

   assign out_free  = !valid_ff || !rsp_stall;
   assign emit      = out_free && job_ready;
   assign ctrl_byte = job.seq ? CTRL_SEQ1 : CTRL_SEQ0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= ST_BEGIN;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      cur = step_ff;
      if (step_ff == ST_BEGIN) begin
         cur = job.start ? ST_HDR_FLAG : ST_DATA0;
      end

      following = ST_BEGIN;
      byte_out  = cfg.flag_value;
      case (cur)
         ST_HDR_FLAG: begin
            byte_out  = cfg.flag_value;
            following = ST_HDR_ADDR;
         end
         ST_HDR_ADDR: begin
            byte_out  = cfg.address_value;
            following = ST_HDR_CTRL;
         end
         ST_HDR_CTRL: begin
            byte_out  = ctrl_byte;
            following = ST_HDR_PAR;
         end
         ST_HDR_PAR: begin
            byte_out  = cfg.address_value ^ ctrl_byte;
            following = ST_DATA0;
         end
         ST_DATA0: begin
            byte_out = (job.data_kind == KIND_PLAIN) ? job.data : cfg.escape_value;
            if (job.data_kind != KIND_PLAIN) begin
               following = ST_DATA1;
            end else if (job.last) begin
               following = ST_PAR0;
            end
         end
         ST_DATA1: begin
            byte_out  = (job.data_kind == KIND_FLAG) ? cfg.flag_code : cfg.escape_code;
            following = job.last ? ST_PAR0 : ST_BEGIN;
         end
         ST_PAR0: begin
            byte_out  = (job.par_kind == KIND_PLAIN) ? job.parity : cfg.escape_value;
            following = (job.par_kind != KIND_PLAIN) ? ST_PAR1 : ST_CLOSE;
         end
         ST_PAR1: begin
            byte_out  = (job.par_kind == KIND_FLAG) ? cfg.flag_code : cfg.escape_code;
            following = ST_CLOSE;
         end
         ST_CLOSE: begin
            byte_out  = cfg.flag_value;
            following = ST_BEGIN;
         end
         default: begin
            byte_out  = cfg.flag_value;
            following = ST_BEGIN;
         end
      endcase

      step_in  = step_ff;
      valid_in = valid_ff;
      pop      = 1'b0;
      if (out_free) begin
         valid_in = emit;
      end
      if (emit) begin
         step_in = following;
         pop     = (following == ST_BEGIN);
      end
   end

   // output register, payload only moves when a new byte is emitted
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff    <= byte_out;
         run_end_ff <= (following == ST_BEGIN);
         done_ff    <= (cur == ST_CLOSE);
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_line_byte  = byte_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_frame_done = done_ff;

endmodule

`default_nettype wire

// ===== src/byte_stuffing_frame_encoder_unit.sv =====
// Top level of the byte stuffing frame encoder: control registers, front, queue, back.
//
// Usage:
//   req_* channel: one payload byte per request, with frame_start, frame_last and
//   sequence_bit. A request is taken when req_valid is high and req_stall low.
//   rsp_* channel: one line byte per response; run_end marks the last byte a request
//   produced, frame_done marks the closing flag.
//   csr_* channel: register writes (0 flag, 1 escape, 2 flag code, 3 escape code,
//   4 address); csr_ready is always high. Write only while the block is idle.
// Timing:
//   A request produces 1 to 9 line bytes. The back end emits one byte per cycle
//   while rsp_stall is low: 1 line byte for a plain byte, 2 for a stuffed one, up
//   to 9 for a one-byte frame. The first byte passes through the queue entry and
//   the output register before it appears. A two-entry queue lets the front
//   take new requests while the back end is still busy.
// Reset: clears the running parity, the queue and the output valid; control
//   registers return to their default values.
// Stall: with rsp_stall high the output byte holds; once the queue fills,
//   req_stall rises.
`default_nettype none

module byte_stuffing_frame_encoder_unit #(
   parameter int QUEUE_DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [bsfe_pkg::BYTE_WIDTH-1:0]       req_payload_byte,
   input  wire                                   req_frame_start,
   input  wire                                   req_frame_last,
   input  wire                                   req_sequence_bit,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [bsfe_pkg::BYTE_WIDTH-1:0]       rsp_line_byte,
   output logic                                  rsp_run_end,
   output logic                                  rsp_frame_done,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [bsfe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [bsfe_pkg::BYTE_WIDTH-1:0]       csr_data
);
   import bsfe_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type push_job, head_job;
   logic    push, pop, queue_full, queue_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FLAG_VALUE:    cfg_in.flag_value    = csr_data;
            CSR_ESCAPE_VALUE:  cfg_in.escape_value  = csr_data;
            CSR_FLAG_CODE:     cfg_in.flag_code     = csr_data;
            CSR_ESCAPE_CODE:   cfg_in.escape_code   = csr_data;
            CSR_ADDRESS_VALUE: cfg_in.address_value = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_value    <= FLAG_VALUE_RESET;
         cfg_ff.escape_value  <= ESCAPE_VALUE_RESET;
         cfg_ff.flag_code     <= FLAG_CODE_RESET;
         cfg_ff.escape_code   <= ESCAPE_CODE_RESET;
         cfg_ff.address_value <= ADDRESS_VALUE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_frame_start  (req_frame_start),
      .req_frame_last   (req_frame_last),
      .req_sequence_bit (req_sequence_bit),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   bsfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   bsfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .job            (head_job),
      .job_ready      (!queue_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_line_byte  (rsp_line_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire

// ===== src/bsfe_checker.sv =====
// Port-level checks of the byte stuffing frame encoder, bound to the top level.
`default_nettype none

module bsfe_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_stall,
   input wire                                  rsp_valid,
   input wire                                  rsp_stall,
   input wire [bsfe_pkg::BYTE_WIDTH-1:0]       rsp_line_byte,
   input wire                                  rsp_run_end,
   input wire                                  rsp_frame_done
);

   // the closing flag is always the final byte of its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_run_end)
      else $error("closing flag without run_end");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_byte)
         && $stable(rsp_run_end) && $stable(rsp_frame_done))
      else $error("stalled response changed");

endmodule

bind byte_stuffing_frame_encoder_unit bsfe_checker u_bsfe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_line_byte  (rsp_line_byte),
   .rsp_run_end    (rsp_run_end),
   .rsp_frame_done (rsp_frame_done)
);

`default_nettype wire
